### rtl/core/fsc_pkg.sv
// Shared constants for the fast sine/cosine approximation pipeline.
// No dependencies; imported by fsc_sine_lane and fast_sine_cosine_approx.
`default_nettype none

package fsc_pkg;

  // Port and datapath widths
  localparam int ANG_W = 32;   // Q16.16 degrees
  localparam int X_W   = 19;   // radians, 16 fraction bits, range [-pi, pi]
  localparam int OUT_W = 16;   // Q1.14

  // Angle reduction: 360 degrees = 360 << 16, so reduce the integer part mod 360
  localparam int DEG360_Q16 = 23592960;
  localparam int DEG180_Q16 = 11796480;
  localparam int DEG_MOD    = 360;
  // Bias that makes the signed integer part positive: 92 * 360 = 33120
  localparam int HI_BIAS    = 352;     // added on top of the 32768 offset
  localparam int RECIP_360  = 46603;   // floor(2^24 / 360)

  // pi/180 in Q0.32, split into two 13-bit halves at bit 14
  localparam int RAD_K_HI = 4575;
  localparam int RAD_K_LO = 4521;

  localparam int HALF_PI_Q16 = 102944;
  localparam int PI_Q16      = 205887;
  localparam int TWO_PI_Q16  = 411775;

  // Parabola and refinement coefficients, 16 fraction bits
  localparam int COEF_B = 83443;
  localparam int COEF_C = 26561;
  localparam int COEF_P = 14746;

  localparam int ONE_Q14 = 16384;

  localparam int LANE_LAT  = 8;
  localparam int FRONT_LAT = 4;

endpackage : fsc_pkg

`default_nettype wire

### rtl/core/fsc_sine_lane.sv
// One parabolic sine evaluation with refinement, eight register stages.
// Depends on fsc_pkg for widths and coefficients.
`default_nettype none

module fsc_sine_lane
  import fsc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic signed [X_W-1:0]   x,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      result
);

  logic [LANE_LAT-1:0] valid;

  logic signed [37:0]  m_sq;      // x*|x|
  logic signed [36:0]  m_b;       // B*x
  logic signed [20:0]  s2_s;
  logic signed [19:0]  s2_t;
  logic signed [36:0]  s3_cs;
  logic signed [19:0]  s3_t;
  logic signed [20:0]  s4_y;
  logic signed [41:0]  s5_yy;
  logic signed [20:0]  s5_y;
  logic signed [21:0]  s6_d;
  logic signed [20:0]  s6_y;
  logic signed [36:0]  s7_pd;
  logic signed [20:0]  s7_y;

  logic signed [37:0]  m_sq_next;
  logic signed [36:0]  m_b_next;
  logic signed [20:0]  s_next;
  logic signed [19:0]  t_next;
  logic signed [36:0]  cs_next;
  logic signed [20:0]  y_next;
  logic signed [41:0]  yy_next;
  logic signed [21:0]  d_next;
  logic signed [36:0]  pd_next;
  logic signed [OUT_W-1:0] result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LANE_LAT-2:0], in_valid};
    end
  end

  // Stage 1: both products of x
  always_comb begin
    logic [X_W-2:0] ax;
    ax        = x[X_W-1] ? (X_W-1)'(-x) : x[X_W-2:0];
    m_sq_next = x * $signed({1'b0, ax});
    m_b_next  = x * 18'(COEF_B);
  end

  // Stage 2: round both products back to 16 fraction bits
  always_comb begin
    logic signed [37:0] rs;
    logic signed [36:0] rb;
    rs     = m_sq + 38'sd32768;
    rb     = m_b + 37'sd32768;
    s_next = 21'(rs >>> 16);
    t_next = 20'(rb >>> 16);
  end

  // Stage 3: C*s
  assign cs_next = s2_s * 16'(COEF_C);

  // Stage 4: parabola y = round(Bx) - round(Cs)
  always_comb begin
    logic signed [36:0] rc;
    rc     = s3_cs + 37'sd32768;
    y_next = 21'(s3_t) - 21'(rc >>> 16);
  end

  // Stage 5: y*|y|
  always_comb begin
    logic [19:0] ay;
    ay      = s4_y[20] ? 20'(-s4_y) : s4_y[19:0];
    yy_next = s4_y * $signed({1'b0, ay});
  end

  // Stage 6: q - y
  always_comb begin
    logic signed [41:0] rq;
    rq     = s5_yy + 42'sd32768;
    d_next = 22'(rq >>> 16) - 22'(s5_y);
  end

  // Stage 7: P*(q - y)
  assign pd_next = s6_d * 16'(COEF_P);

  // Stage 8: refine, drop two fraction bits, clamp to +/-1.0
  always_comb begin
    logic signed [36:0] rp;
    logic signed [21:0] y2;
    logic signed [19:0] z;
    rp = s7_pd + 37'sd32768;
    y2 = 22'(s7_y) + 22'(rp >>> 16);
    z  = 20'((y2 + 22'sd2) >>> 2);
    if (z > 20'(ONE_Q14)) begin
      result_next = OUT_W'(ONE_Q14);
    end else if (z < -20'(ONE_Q14)) begin
      result_next = -OUT_W'(ONE_Q14);
    end else begin
      result_next = OUT_W'(z);
    end
  end

  always_ff @(posedge clk) begin
    m_sq   <= m_sq_next;
    m_b    <= m_b_next;
    s2_s   <= s_next;
    s2_t   <= t_next;
    s3_cs  <= cs_next;
    s3_t   <= s2_t;
    s4_y   <= y_next;
    s5_yy  <= yy_next;
    s5_y   <= s4_y;
    s6_d   <= d_next;
    s6_y   <= s5_y;
    s7_pd  <= pd_next;
    s7_y   <= s6_y;
    result <= result_next;
  end

  assign out_valid = valid[LANE_LAT-1];

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result <= 16'sd16384 && result >= -16'sd16384))
    else $error("lane result outside +/-1.0");

  a_lane_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##8 out_valid)
    else $error("lane beat lost");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, LANE_LAT))
    else $error("lane output without a matching input");

endmodule : fsc_sine_lane

`default_nettype wire

### rtl/core/fast_sine_cosine_approx.sv
// Done strobes for each accepted start once it has passed the front and lane stages.
// Throughput: one angle per cycle; busy is low whenever rst is low.
// Four front stages reduce mod 360 and scale to radians, then two eight-stage
// sine lanes run in parallel (the cosine lane sees the angle plus pi/2).
// Reset (rst, synchronous) clears all valid bits; in-flight beats are dropped.
// Top level of the sine/cosine approximation; uses fsc_pkg and fsc_sine_lane.
`default_nettype none

module fast_sine_cosine_approx
  import fsc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [ANG_W-1:0] angle_deg,
  output logic                         done,
  output logic signed [OUT_W-1:0]      sine_out,
  output logic signed [OUT_W-1:0]      cosine_out
);

  localparam int LATENCY = FRONT_LAT + LANE_LAT;

  logic                    accept;
  logic [FRONT_LAT-1:0]    valid;

  logic [15:0]             s1_lo;
  logic [16:0]             s1_hu;
  logic [7:0]              s1_q;
  logic signed [24:0]      s2_r;
  logic signed [38:0]      s3_ph;
  logic signed [38:0]      s3_pl;
  logic signed [X_W-1:0]   s4_x;
  logic signed [X_W-1:0]   s4_xc;

  logic [16:0]             hu_next;
  logic [7:0]              q_next;
  logic signed [24:0]      r_next;
  logic signed [38:0]      ph_next;
  logic signed [38:0]      pl_next;
  logic signed [X_W-1:0]   x_next;
  logic signed [X_W-1:0]   xc_next;

  logic                    sin_valid;
  logic                    cos_valid;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[FRONT_LAT-2:0], accept};
    end
  end

  // Stage 1: bias the integer degrees positive, estimate quotient by 360
  always_comb begin
    logic [32:0] prod;
    hu_next = 17'({1'b0, ~angle_deg[31], angle_deg[30:16]}) + 17'(HI_BIAS);
    prod    = 33'(hu_next) * 33'(RECIP_360);
    q_next  = prod[31:24];
  end

  // Stage 2: finish the remainder, then fold into (-180, 180]
  always_comb begin
    logic [16:0] qm;
    logic [9:0]  rem;
    logic [8:0]  hm;
    logic [24:0] r_pos;
    qm  = 17'(s1_q) * 17'(DEG_MOD);
    rem = 10'(s1_hu - qm);
    if (rem >= 10'(DEG_MOD)) begin
      hm = 9'(rem - 10'(DEG_MOD));
    end else begin
      hm = rem[8:0];
    end
    r_pos = {hm, s1_lo};
    if (r_pos > 25'(DEG180_Q16)) begin
      r_next = $signed(r_pos - 25'(DEG360_Q16));
    end else begin
      r_next = $signed(r_pos);
    end
  end

  // Stage 3: degrees to radians, product split in two halves
  assign ph_next = s2_r * $signed({1'b0, 13'(RAD_K_HI)});
  assign pl_next = s2_r * $signed({1'b0, 13'(RAD_K_LO)});

  // Stage 4: combine, round off 32 bits, form the cosine argument
  always_comb begin
    logic signed [51:0] acc;
    logic signed [19:0] xs;
    acc     = (52'(s3_ph) <<< 14) + 52'(s3_pl) + (52'sd1 <<< 31);
    x_next  = X_W'(acc >>> 32);
    xs      = 20'(x_next) + 20'(HALF_PI_Q16);
    if (xs > 20'(PI_Q16)) begin
      xs = xs - 20'(TWO_PI_Q16);
    end
    xc_next = X_W'(xs);
  end

  always_ff @(posedge clk) begin
    s1_lo <= angle_deg[15:0];
    s1_hu <= hu_next;
    s1_q  <= q_next;
    s2_r  <= r_next;
    s3_ph <= ph_next;
    s3_pl <= pl_next;
    s4_x  <= x_next;
    s4_xc <= xc_next;
  end

  fsc_sine_lane u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[FRONT_LAT-1]),
    .x         (s4_x),
    .out_valid (sin_valid),
    .result    (sine_out)
  );

  fsc_sine_lane u_cosine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[FRONT_LAT-1]),
    .x         (s4_xc),
    .out_valid (cos_valid),
    .result    (cosine_out)
  );

  assign done = sin_valid;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    sin_valid == cos_valid)
    else $error("sine and cosine lanes out of step");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##12 done)
    else $error("accepted beat did not complete");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("done without a matching start");

endmodule : fast_sine_cosine_approx

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for fast_sine_cosine_approx: directed and random angles in degrees,
// expected sine/cosine worked out in fixed point and compared beat by beat.
// Depends on fsc_pkg and the fast_sine_cosine_approx RTL.

module tb;
  import fsc_pkg::*;

  localparam longint RAD_PER_DEG = 74961321;  // pi/180 scaled by 2^32
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct {
    logic [ANG_W-1:0]        angle;
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } trig_pair_t;

  class trig_scoreboard;
    trig_pair_t expected_q[$];
    int unsigned errors;

    // round half up, then floor
    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // x carries 16 fraction bits, within [-pi, pi]
    function logic signed [OUT_W-1:0] parabola_sine(longint x);
      longint s;
      longint y;
      longint q;
      longint z;
      s = rnd_shift(x * mag(x), 16);
      y = rnd_shift(longint'(COEF_B) * x, 16) - rnd_shift(longint'(COEF_C) * s, 16);
      q = rnd_shift(y * mag(y), 16);
      y = y + rnd_shift(longint'(COEF_P) * (q - y), 16);
      z = rnd_shift(y, 2);
      if (z > ONE_Q14) z = ONE_Q14;
      if (z < -ONE_Q14) z = -ONE_Q14;
      return z[OUT_W-1:0];
    endfunction

    function void note_angle(logic [ANG_W-1:0] angle);
      longint a;
      longint r;
      longint x;
      longint xc;
      trig_pair_t p;
      a = longint'($signed(angle));
      r = a % longint'(DEG360_Q16);
      if (r < 0) r += DEG360_Q16;
      if (r > DEG180_Q16) r -= DEG360_Q16;
      x = rnd_shift(r * RAD_PER_DEG, 32);
      // cosine lane: shift by pi/2, wrap once past pi
      xc = x + HALF_PI_Q16;
      if (xc > PI_Q16) xc -= TWO_PI_Q16;
      p.angle = angle;
      p.sine = parabola_sine(x);
      p.cosine = parabola_sine(xc);
      expected_q.push_back(p);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] sine,
                               logic signed [OUT_W-1:0] cosine);
      trig_pair_t p;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat: sine %0d cosine %0d", $time, sine, cosine);
        errors++;
        return;
      end
      p = expected_q.pop_front();
      if (sine !== p.sine) begin
        $display("%0t: sine mismatch, angle %h: expected %0d, actual %0d",
                 $time, p.angle, p.sine, sine);
        errors++;
      end
      if (cosine !== p.cosine) begin
        $display("%0t: cosine mismatch, angle %h: expected %0d, actual %0d",
                 $time, p.angle, p.cosine, cosine);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [ANG_W-1:0] angle_deg;
  logic                    done;
  logic signed [OUT_W-1:0] sine_out;
  logic signed [OUT_W-1:0] cosine_out;

  trig_scoreboard sb;
  int unsigned idle_cycles;

  fast_sine_cosine_approx u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .angle_deg  (angle_deg),
    .done       (done),
    .sine_out   (sine_out),
    .cosine_out (cosine_out)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sample at the edge; both sides update by nonblocking assignment.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_angle(angle_deg);
      if (done) sb.check_result(sine_out, cosine_out);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [ANG_W-1:0] deg_q16(int d);
    return ANG_W'(d) <<< 16;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 60);
  endfunction

  function automatic logic [ANG_W-1:0] random_angle();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom;
    if (r < 55) return $urandom_range(0, 800 << 16) - (400 << 16);
    if (r < 75) begin
      // land near multiples of 90 degrees, where folding and saturation bite
      k = $urandom_range(0, 40) - 20;
      return deg_q16(k * 90) + ANG_W'($urandom_range(0, 512)) - 256;
    end
    if (r < 80) begin
      if ($urandom_range(0, 1)) return 32'h7FFF_FFFF - $urandom_range(0, 65536);
      return 32'h8000_0000 + $urandom_range(0, 65536);
    end
    return deg_q16($urandom_range(0, 1440) - 720);
  endfunction

  // Hold start with the angle until the block takes the beat.
  task automatic send_angle(input logic [ANG_W-1:0] a, input int gap);
    bit took;
    if (gap > 0) begin
      start <= 1'b0;
      angle_deg <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    angle_deg <= a;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  logic [ANG_W-1:0] directed_angles[$];
  bit burst;

  initial begin
    sb = new();
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    angle_deg = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_angles = '{
      deg_q16(0), deg_q16(90), deg_q16(-90), deg_q16(180), deg_q16(-180),
      deg_q16(270), deg_q16(-270), deg_q16(360), deg_q16(45), deg_q16(-45),
      deg_q16(30), deg_q16(135), deg_q16(720), deg_q16(-540),
      deg_q16(180) - 1, deg_q16(180) + 1, deg_q16(-180) + 1, deg_q16(-180) - 1,
      deg_q16(90) - 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h0000_FFFF
    };
    foreach (directed_angles[i])
      send_angle(directed_angles[i], (i % 3 == 0) ? 0 : pick_gap());

    burst = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      send_angle(random_angle(), burst ? 0 : pick_gap());
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // catch any stray beat still in the pipe
    repeat (FRONT_LAT + LANE_LAT + 8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
